/* rtl/qmv_pkg.sv */
package qmv_pkg;

   // Parameter defaults and fixed limits
   localparam int MAX_ROW_LENGTH_DEF = 16384;
   localparam int MAX_GROUP_SIZE_DEF = 256;
   localparam int MAX_ROW_COUNT      = 16384;

   // Register and field widths
   localparam int ROW_LENGTH_W = 15;
   localparam int GROUP_SIZE_W = 9;
   localparam int ROW_COUNT_W  = 15;
   localparam int ROW_INDEX_W  = 14;
   localparam int CSR_DATA_W   = 15;
   localparam int CSR_INDEX_W  = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_SIZE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT  = 2'd2;

   // Register reset values
   localparam logic [ROW_LENGTH_W-1:0] RST_ROW_LENGTH = 15'd64;
   localparam logic [GROUP_SIZE_W-1:0] RST_GROUP_SIZE = 9'd32;
   localparam logic [ROW_COUNT_W-1:0]  RST_ROW_COUNT  = 15'd1;

   // float32 encodings
   localparam logic [31:0] F32_QNAN     = 32'h7fc0_0000;
   localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;
   localparam logic [30:0] F32_INF_MAG  = 31'h7f80_0000;

   localparam int QUEUE_DEPTH = 4;

   // One unit of work for the float back end
   typedef struct packed {
      logic                   grp;      // a group closed: accumulate it
      logic                   row_end;  // emit the row sum afterwards
      logic                   last;
      logic [ROW_INDEX_W-1:0] row_idx;
      logic [31:0]            int_sum;
      logic [31:0]            act_scale;
      logic [31:0]            wgt_scale;
   } job_type;

endpackage

/* rtl/qmv_req_if.sv */
interface qmv_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] act_q;
   logic signed [7:0] wgt_q;
   logic [31:0]       act_scale;
   logic [31:0]       wgt_scale;

   modport source (output valid, act_q, wgt_q, act_scale, wgt_scale, input ready);
   modport sink   (input valid, act_q, wgt_q, act_scale, wgt_scale, output ready);
endinterface

/* rtl/qmv_rsp_if.sv */
interface qmv_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] row_sum;
   logic [13:0] row_index;
   logic        last_row;

   modport source (output valid, row_sum, row_index, last_row, input ready);
   modport sink   (input valid, row_sum, row_index, last_row, output ready);
endinterface

/* rtl/qmv_front.sv */
module qmv_front #(
   parameter int MAX_ROW_LENGTH = qmv_pkg::MAX_ROW_LENGTH_DEF,
   parameter int MAX_GROUP_SIZE = qmv_pkg::MAX_GROUP_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   qmv_req_if.sink                          req_ch,
   input  logic                             csr_wr_en,
   input  logic [qmv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qmv_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             push_valid,
   output qmv_pkg::job_type                 push_job,
   input  logic                             push_ready
);

   localparam int LW  = $clog2(MAX_ROW_LENGTH + 1);
   localparam int GW  = $clog2(MAX_GROUP_SIZE + 1);
   localparam int RCW = $clog2(qmv_pkg::MAX_ROW_COUNT + 1);
   localparam int RIW = qmv_pkg::ROW_INDEX_W;
   localparam int LCW = $clog2(LW + 1);

   function automatic logic [LW-1:0] clamp_len(input logic [qmv_pkg::ROW_LENGTH_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) return LW'(1);
      else if (w > 32'(MAX_ROW_LENGTH)) return LW'(MAX_ROW_LENGTH);
      else return LW'(w);
   endfunction

   function automatic logic [GW-1:0] clamp_gs(input logic [qmv_pkg::GROUP_SIZE_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) return GW'(1);
      else if (w > 32'(MAX_GROUP_SIZE)) return GW'(MAX_GROUP_SIZE);
      else return GW'(w);
   endfunction

   function automatic logic [RCW-1:0] clamp_rc(input logic [qmv_pkg::ROW_COUNT_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w == 32'd0) return RCW'(1);
      else if (w > 32'(qmv_pkg::MAX_ROW_COUNT)) return RCW'(qmv_pkg::MAX_ROW_COUNT);
      else return RCW'(w);
   endfunction

   logic [LW-1:0]  n_ff, n_in, whole_ff, whole_in, dsh_ff, dsh_in, ep_ff, ep_in;
   logic [GW-1:0]  gs_ff, gs_in, rem_ff, rem_in, gp_ff, gp_in;
   logic [RCW-1:0] rc_ff, rc_in;
   logic [LCW-1:0] dcnt_ff, dcnt_in;
   logic           busy_ff, busy_in;
   logic [31:0]    sum_ff, sum_in;
   logic [RIW-1:0] row_ff, row_in;

   logic              acc;
   logic signed [15:0] prod;
   logic [31:0]       sum_add;
   logic              in_whole, gclose, rend, last;
   logic [GW-1:0]     gp_inc;
   logic [LW-1:0]     ep_inc;
   logic [GW:0]       dtrial;
   logic [GW-1:0]     rem_next;

   assign req_ch.ready = !busy_ff && push_ready;
   assign acc          = req_ch.valid && req_ch.ready;

   assign prod     = req_ch.act_q * req_ch.wgt_q;
   assign sum_add  = sum_ff + {{16{prod[15]}}, prod};
   assign in_whole = ep_ff < whole_ff;
   assign gp_inc   = gp_ff + GW'(1);
   assign ep_inc   = ep_ff + LW'(1);
   assign gclose   = in_whole && (gp_inc >= gs_ff);
   assign rend     = ep_inc >= n_ff;
   assign last     = (RCW'(row_ff) + RCW'(1)) >= rc_ff;

   // restoring remainder step: n mod group_size, one bit per cycle
   assign dtrial   = {rem_ff, dsh_ff[LW-1]};
   assign rem_next = (dtrial >= {1'b0, gs_ff}) ? GW'(dtrial - {1'b0, gs_ff}) : GW'(dtrial);

   always_comb begin
      push_valid        = acc && (gclose || rend);
      push_job.grp      = gclose;
      push_job.row_end  = rend;
      push_job.last     = last;
      push_job.row_idx  = row_ff;
      push_job.int_sum  = sum_add;
      push_job.act_scale = req_ch.act_scale;
      push_job.wgt_scale = req_ch.wgt_scale;
   end

   always_comb begin
      n_in     = n_ff;
      gs_in    = gs_ff;
      rc_in    = rc_ff;
      whole_in = whole_ff;
      dsh_in   = dsh_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      busy_in  = busy_ff;
      ep_in    = ep_ff;
      gp_in    = gp_ff;
      sum_in   = sum_ff;
      row_in   = row_ff;

      if (csr_wr_en) begin
         if (csr_index == qmv_pkg::CSR_ROW_LENGTH) begin
            n_in = clamp_len(qmv_pkg::ROW_LENGTH_W'(csr_wdata));
         end
         if (csr_index == qmv_pkg::CSR_GROUP_SIZE) begin
            gs_in = clamp_gs(csr_wdata[qmv_pkg::GROUP_SIZE_W-1:0]);
         end
         if (csr_index == qmv_pkg::CSR_ROW_COUNT) begin
            rc_in = clamp_rc(qmv_pkg::ROW_COUNT_W'(csr_wdata));
         end
         busy_in = 1'b1;
         dcnt_in = LCW'(LW);
         dsh_in  = n_in;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = rem_next;
         dsh_in  = dsh_ff << 1;
         dcnt_in = dcnt_ff - LCW'(1);
         if (dcnt_ff == LCW'(1)) begin
            busy_in  = 1'b0;
            whole_in = n_ff - LW'(rem_next);
         end
      end

      if (acc) begin
         if (in_whole) begin
            sum_in = sum_add;
            gp_in  = gp_inc;
         end
         if (gclose) begin
            sum_in = '0;
            gp_in  = '0;
         end
         ep_in = ep_inc;
         if (rend) begin
            ep_in  = '0;
            gp_in  = '0;
            sum_in = '0;
            row_in = last ? '0 : row_ff + RIW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= clamp_len(qmv_pkg::RST_ROW_LENGTH);
         gs_ff   <= clamp_gs(qmv_pkg::RST_GROUP_SIZE);
         rc_ff   <= clamp_rc(qmv_pkg::RST_ROW_COUNT);
         busy_ff <= 1'b1;
         dcnt_ff <= LCW'(LW);
         dsh_ff  <= clamp_len(qmv_pkg::RST_ROW_LENGTH);
         rem_ff  <= '0;
         ep_ff   <= '0;
         gp_ff   <= '0;
         sum_ff  <= '0;
         row_ff  <= '0;
      end else begin
         n_ff    <= n_in;
         gs_ff   <= gs_in;
         rc_ff   <= rc_in;
         busy_ff <= busy_in;
         dcnt_ff <= dcnt_in;
         dsh_ff  <= dsh_in;
         rem_ff  <= rem_in;
         ep_ff   <= ep_in;
         gp_ff   <= gp_in;
         sum_ff  <= sum_in;
         row_ff  <= row_in;
      end
      whole_ff <= whole_in;
   end

endmodule

/* rtl/qmv_fifo.sv */
module qmv_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  qmv_pkg::job_type push_job,
   output logic             push_ready,
   output logic             pop_valid,
   output qmv_pkg::job_type pop_job,
   input  logic             pop_ready
);

   localparam int DEPTH = qmv_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   qmv_pkg::job_type mem [DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign push_ready = cnt_ff != CW'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_job    = mem[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + PW'(1);
      end
      if (do_pop) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem[wp_ff] <= push_job;
      end
   end

endmodule

/* rtl/qmv_back.sv */
module qmv_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   input  qmv_pkg::job_type pop_job,
   output logic             pop_ready,
   qmv_rsp_if.source        rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_NORM, S_SHR, S_FSET, S_PACK_P, S_ORDER, S_ADD, S_RND, S_PACK, S_DONE, S_EMIT
   } state_type;

   typedef enum logic [1:0] {OP_CONV, OP_SCALE, OP_ROW} op_type;

   state_type        state_ff, state_in, ret_ff, ret_in;
   op_type           op_ff, op_in;
   qmv_pkg::job_type job_ff, job_in;
   logic [63:0]      acc_ff, acc_in, lg_ff, lg_in;
   logic signed [11:0] ex_ff, ex_in, el_ff, el_in, ec_ff, ec_in;
   logic [5:0]       amt_ff, amt_in;
   logic             sign_ff, sign_in, same_ff, same_in, sc_ff, sc_in;
   logic [23:0]      mc_ff, mc_in;
   logic [7:0]       eb_ff, eb_in;
   logic [31:0]      res_ff, res_in, cv_ff, cv_in, x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [31:0]      rsum_ff, rsum_in, osum_ff, osum_in;
   logic [13:0]      oidx_ff, oidx_in;
   logic             ov_ff, ov_in, olast_ff, olast_in;

   // operand decode for the fused multiply-add
   logic [7:0]  fa, fb, fc;
   logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero, sp;
   logic [23:0] ma, mb;
   logic [47:0] prod48;
   logic signed [11:0] ea, eb;

   assign fa     = x_ff[30:23];
   assign fb     = y_ff[30:23];
   assign fc     = z_ff[30:23];
   assign a_nan  = fa == 8'hff && x_ff[22:0] != '0;
   assign b_nan  = fb == 8'hff && y_ff[22:0] != '0;
   assign c_nan  = fc == 8'hff && z_ff[22:0] != '0;
   assign a_inf  = fa == 8'hff && x_ff[22:0] == '0;
   assign b_inf  = fb == 8'hff && y_ff[22:0] == '0;
   assign c_inf  = fc == 8'hff && z_ff[22:0] == '0;
   assign a_zero = fa == '0 && x_ff[22:0] == '0;
   assign b_zero = fb == '0 && y_ff[22:0] == '0;
   assign c_zero = fc == '0 && z_ff[22:0] == '0;
   assign sp     = x_ff[31] ^ y_ff[31];
   assign ma     = {fa != '0, x_ff[22:0]};
   assign mb     = {fb != '0, y_ff[22:0]};
   assign prod48 = ma * mb;
   assign ea     = (fa != '0) ? $signed({4'b0, fa}) - 12'sd150 : -12'sd149;
   assign eb     = (fb != '0) ? $signed({4'b0, fb}) - 12'sd150 : -12'sd149;

   // alignment and rounding helpers
   logic [63:0]        mcn, addsum;
   logic signed [11:0] ecn, dd, rnd_e, rnd_sh;
   logic               big;
   logic [24:0]        mant;

   assign mcn    = acc_ff >> 2;
   assign ecn    = ex_ff + 12'sd2;
   assign big    = (el_ff > ecn) || (el_ff == ecn && lg_ff >= mcn);
   assign dd     = big ? el_ff - ecn : ecn - el_ff;
   assign addsum = same_ff ? lg_ff + acc_ff : lg_ff - acc_ff;
   assign rnd_e  = ex_ff + 12'sd190;
   assign rnd_sh = (rnd_e >= 12'sd1) ? 12'sd40 : 12'sd41 - rnd_e;
   assign mant   = {1'b0, acc_ff[25:2]} + 25'(acc_ff[1] && (acc_ff[0] || acc_ff[2]));

   assign pop_ready        = state_ff == S_IDLE;
   assign rsp_ch.valid     = ov_ff;
   assign rsp_ch.row_sum   = osum_ff;
   assign rsp_ch.row_index = oidx_ff;
   assign rsp_ch.last_row  = olast_ff;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      op_in    = op_ff;
      job_in   = job_ff;
      acc_in   = acc_ff;
      lg_in    = lg_ff;
      ex_in    = ex_ff;
      el_in    = el_ff;
      ec_in    = ec_ff;
      amt_in   = amt_ff;
      sign_in  = sign_ff;
      same_in  = same_ff;
      sc_in    = sc_ff;
      mc_in    = mc_ff;
      eb_in    = eb_ff;
      res_in   = res_ff;
      cv_in    = cv_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      rsum_in  = rsum_ff;
      osum_in  = osum_ff;
      oidx_in  = oidx_ff;
      olast_in = olast_ff;
      ov_in    = ov_ff;

      if (ov_ff && rsp_ch.ready) begin
         ov_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               job_in = pop_job;
               if (pop_job.grp) begin
                  op_in = OP_CONV;
                  if (pop_job.int_sum == '0) begin
                     res_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     sign_in  = pop_job.int_sum[31];
                     acc_in   = {32'b0, pop_job.int_sum[31] ? 32'd0 - pop_job.int_sum
                                                            : pop_job.int_sum};
                     ex_in    = '0;
                     ret_in   = S_RND;
                     state_in = S_NORM;
                  end
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_NORM: begin
            if (acc_ff[63:48] == '0) begin
               acc_in = acc_ff << 16;
               ex_in  = ex_ff - 12'sd16;
            end else if (acc_ff[63:60] == '0) begin
               acc_in = acc_ff << 4;
               ex_in  = ex_ff - 12'sd4;
            end else if (!acc_ff[63]) begin
               acc_in = acc_ff << 1;
               ex_in  = ex_ff - 12'sd1;
            end else begin
               state_in = ret_ff;
            end
         end
         S_SHR: begin
            // right shift, shifted-out bits jammed into bit 0
            if (amt_ff == '0) begin
               state_in = ret_ff;
            end else if (amt_ff >= 6'd16) begin
               acc_in = {16'b0, acc_ff[63:16]} | 64'(|acc_ff[15:0]);
               amt_in = amt_ff - 6'd16;
            end else if (amt_ff >= 6'd4) begin
               acc_in = {4'b0, acc_ff[63:4]} | 64'(|acc_ff[3:0]);
               amt_in = amt_ff - 6'd4;
            end else begin
               acc_in = {1'b0, acc_ff[63:1]} | 64'(acc_ff[0]);
               amt_in = amt_ff - 6'd1;
            end
         end
         S_FSET: begin
            state_in = S_DONE;
            if (a_nan || b_nan || c_nan) begin
               res_in = qmv_pkg::F32_QNAN;
            end else if (a_inf || b_inf) begin
               if (a_zero || b_zero || (c_inf && z_ff[31] != sp)) begin
                  res_in = qmv_pkg::F32_QNAN;
               end else begin
                  res_in = {sp, qmv_pkg::F32_INF_MAG};
               end
            end else if (c_inf) begin
               res_in = z_ff;
            end else if (a_zero || b_zero) begin
               res_in = c_zero ? {sp & z_ff[31], 31'b0} : z_ff;
            end else begin
               acc_in   = {16'b0, prod48};
               ex_in    = ea + eb;
               sign_in  = sp;
               sc_in    = z_ff[31];
               mc_in    = {fc != '0, z_ff[22:0]};
               ec_in    = (fc != '0) ? $signed({4'b0, fc}) - 12'sd150 : -12'sd149;
               ret_in   = c_zero ? S_RND : S_PACK_P;
               state_in = S_NORM;
            end
         end
         S_PACK_P: begin
            lg_in    = acc_ff >> 2;
            el_in    = ex_ff + 12'sd2;
            acc_in   = {40'b0, mc_ff};
            ex_in    = ec_ff;
            ret_in   = S_ORDER;
            state_in = S_NORM;
         end
         S_ORDER: begin
            same_in = sign_ff == sc_ff;
            if (big) begin
               acc_in = mcn;
            end else begin
               lg_in   = mcn;
               el_in   = ecn;
               sign_in = sc_ff;
               acc_in  = lg_ff;
            end
            if (dd >= 12'sd64) begin
               acc_in = 64'd1;
               amt_in = '0;
            end else begin
               amt_in = dd[5:0];
            end
            ret_in   = S_ADD;
            state_in = S_SHR;
         end
         S_ADD: begin
            if (!same_ff && addsum == '0) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               acc_in   = addsum;
               ex_in    = el_ff;
               ret_in   = S_RND;
               state_in = S_NORM;
            end
         end
         S_RND: begin
            if (rnd_e >= 12'sd255) begin
               res_in   = {sign_ff, qmv_pkg::F32_INF_MAG};
               state_in = S_DONE;
            end else if (rnd_sh > 12'sd64) begin
               res_in   = {sign_ff, 31'b0};
               state_in = S_DONE;
            end else begin
               amt_in   = 6'(rnd_sh - 12'sd2);
               eb_in    = (rnd_e >= 12'sd1) ? 8'(rnd_e - 12'sd1) : 8'd0;
               ret_in   = S_PACK;
               state_in = S_SHR;
            end
         end
         S_PACK: begin
            res_in   = {sign_ff, {eb_ff, 23'b0} + 31'(mant)};
            state_in = S_DONE;
         end
         S_DONE: begin
            unique case (op_ff)
               OP_CONV: begin
                  cv_in    = res_ff;
                  x_in     = job_ff.act_scale;
                  y_in     = job_ff.wgt_scale;
                  z_in     = qmv_pkg::F32_NEG_ZERO;
                  op_in    = OP_SCALE;
                  state_in = S_FSET;
               end
               OP_SCALE: begin
                  x_in     = cv_ff;
                  y_in     = res_ff;
                  z_in     = rsum_ff;
                  op_in    = OP_ROW;
                  state_in = S_FSET;
               end
               OP_ROW: begin
                  rsum_in  = res_ff;
                  state_in = job_ff.row_end ? S_EMIT : S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_EMIT: begin
            if (!ov_ff || rsp_ch.ready) begin
               ov_in    = 1'b1;
               osum_in  = rsum_ff;
               oidx_in  = job_ff.row_idx;
               olast_in = job_ff.last;
               rsum_in  = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         op_ff    <= OP_CONV;
         rsum_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         op_ff    <= op_in;
         rsum_ff  <= rsum_in;
         ov_ff    <= ov_in;
      end
      job_ff   <= job_in;
      acc_ff   <= acc_in;
      lg_ff    <= lg_in;
      ex_ff    <= ex_in;
      el_ff    <= el_in;
      ec_ff    <= ec_in;
      amt_ff   <= amt_in;
      sign_ff  <= sign_in;
      same_ff  <= same_in;
      sc_ff    <= sc_in;
      mc_ff    <= mc_in;
      eb_ff    <= eb_in;
      res_ff   <= res_in;
      cv_ff    <= cv_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      osum_ff  <= osum_in;
      oidx_ff  <= oidx_in;
      olast_ff <= olast_in;
   end

   // normalizer only ever runs on a nonzero significand
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NORM |-> acc_ff != '0)
      else $error("normalize on zero significand");

   // rounding shift leaves at most 24 mantissa bits plus guard and sticky
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PACK |-> acc_ff[63:26] == '0)
      else $error("rounding shift left too many bits");

   // emitting a row loads the output register and restarts the row sum
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && (!ov_ff || rsp_ch.ready) |=> ov_ff && rsum_ff == '0)
      else $error("row emit lost");

endmodule

/* rtl/int8_group_quantized_matvec_core.sv */
// Row result: the row's last element enters the job queue, the back end takes the job and its emit
//   state loads the output register; a group that closes on that element adds its float work first.
// Throughput: one element transfer per cycle while the front end is not busy and the 4-entry job
//   queue has room; each closed group holds the float back end on its shared normalize/shift unit.
// Reset: synchronous, active high. Clears all counters, the row sum, the queue and the output
//   valid; req_ch.ready stays low while the whole-group bound is derived, likewise after a csr write.
module int8_group_quantized_matvec_core #(
   parameter int MAX_ROW_LENGTH = qmv_pkg::MAX_ROW_LENGTH_DEF,
   parameter int MAX_GROUP_SIZE = qmv_pkg::MAX_GROUP_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   qmv_req_if.sink                         req_ch,
   qmv_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [qmv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qmv_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Front end: takes one element per transfer, keeps the integer group sum and the
   // element/group/row counters, and emits a job when a group closes or a row ends.
   // It also holds the config and derives the whole-group bound with a bit-serial remainder.
   qmv_pkg::job_type push_job, pop_job;
   logic             push_valid, push_ready;
   logic             pop_valid, pop_ready;

   qmv_front #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
      .MAX_GROUP_SIZE (MAX_GROUP_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   // Short queue so the front keeps streaming while the float unit works on a group.
   qmv_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   // Back end: sequenced float32 datapath (24x24 multiplier, stepwise normalize and
   // sticky right shift, 64-bit add, round-to-nearest-even pack). Per group it converts
   // the integer sum, forms the scale product, folds it into the row sum with one rounding,
   // and on row end moves the sum into the output register, which frees it for the next row.
   qmv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* dv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Row result as it leaves the block, plus an optional hand-typed sum
   typedef struct {
      logic [31:0]                     sum;
      logic [qmv_pkg::ROW_INDEX_W-1:0] idx;
      logic                            last;
      logic                            hand_set;
      logic [31:0]                     hand_sum;
   } row_result_type;

   // One row of the directed table
   typedef struct {
      logic signed [7:0] act;
      logic signed [7:0] wgt;
      logic [31:0]       act_scale;
      logic [31:0]       wgt_scale;
      logic              hand_set;
      logic [31:0]       hand_sum;
   } dir_row_type;

   localparam int DRAIN_CYCLES = 500;   // covers a full job queue of slow groups

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_wr_en = 1'b0;
   logic [qmv_pkg::CSR_INDEX_W-1:0] csr_index = qmv_pkg::CSR_ROW_LENGTH;
   logic [qmv_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   qmv_req_if req ();
   qmv_rsp_if rsp ();

   int8_group_quantized_matvec_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Golden matvec model: register copies, running position / sums, expected row results
   // ---------------------------------------------------------------------------------------
   logic [qmv_pkg::ROW_LENGTH_W-1:0] mv_row_length = qmv_pkg::RST_ROW_LENGTH;
   logic [qmv_pkg::GROUP_SIZE_W-1:0] mv_group_size = qmv_pkg::RST_GROUP_SIZE;
   logic [qmv_pkg::ROW_COUNT_W-1:0]  mv_row_count  = qmv_pkg::RST_ROW_COUNT;
   int unsigned mv_elem_pos = 0;
   int unsigned mv_group_pos = 0;
   logic [31:0] mv_int_sum = '0;
   logic [31:0] mv_row_acc = '0;
   int unsigned mv_cur_row = 0;

   row_result_type row_sums_due[$];

   int errors = 0;
   int items_sent = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   task automatic report(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic int clz64(input logic [63:0] v);
      int n;
      n = 0;
      while (n < 64 && !v[63]) begin
         v = v << 1;
         n++;
      end
      return n;
   endfunction

   // sig * 2^exp to float32, round to nearest even, subnormals kept
   function automatic logic [31:0] f32_round(input logic [31:0] sign, input logic [63:0] sig,
                                             input int exp);
      int n, e, sh;
      logic [63:0] mant;
      logic rbit, sticky;
      logic [31:0] eb;
      n = clz64(sig);
      sig = sig << n;
      exp = exp - n;
      e = exp + 63 + 127;
      if (e >= 255) return sign | 32'h7f80_0000;
      sh = (e >= 1) ? 40 : 41 - e;
      if (sh > 64) return sign;
      if (sh == 64) begin
         mant = '0;
         rbit = 1'b1;
         sticky = (sig << 1) != 0;
      end else begin
         mant = sig >> sh;
         rbit = sig[sh-1];
         sticky = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
      end
      if (rbit && (sticky || mant[0])) mant++;
      eb = (e >= 1) ? 32'(e - 1) : 32'd0;
      return sign | ((eb << 23) + mant[31:0]);
   endfunction

   // a * b + c, single rounding
   function automatic logic [31:0] f32_fma(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
      logic [7:0] fa, fb, fc;
      logic [31:0] sa, sb, sc, sp, sl;
      logic [63:0] ma, mb, mc, p, lg, sm;
      int ea, eb, ec, ep, el, es, d;
      fa = a[30:23]; fb = b[30:23]; fc = c[30:23];
      sa = a & 32'h8000_0000; sb = b & 32'h8000_0000; sc = c & 32'h8000_0000;
      sp = sa ^ sb;
      ma = {41'd0, a[22:0]}; mb = {41'd0, b[22:0]}; mc = {41'd0, c[22:0]};
      if ((fa == 8'hff && ma != 0) || (fb == 8'hff && mb != 0) || (fc == 8'hff && mc != 0))
         return qmv_pkg::F32_QNAN;
      if (fa == 8'hff || fb == 8'hff) begin
         if ((fa == 0 && ma == 0) || (fb == 0 && mb == 0)) return qmv_pkg::F32_QNAN;
         if (fc == 8'hff && sc != sp) return qmv_pkg::F32_QNAN;
         return sp | 32'h7f80_0000;
      end
      if (fc == 8'hff) return c;
      if (fa != 0) begin ma |= 64'h80_0000; ea = int'(fa) - 150; end else ea = -149;
      if (fb != 0) begin mb |= 64'h80_0000; eb = int'(fb) - 150; end else eb = -149;
      if (fc != 0) begin mc |= 64'h80_0000; ec = int'(fc) - 150; end else ec = -149;
      if (ma == 0 || mb == 0) begin
         if (mc == 0) return sp & sc;
         return c;
      end
      p = ma * mb;
      ep = ea + eb;
      if (mc == 0) return f32_round(sp, p, ep);
      // line both up with the leading one at bit 61
      d = clz64(p) - 2;
      p = p << d;
      ep -= d;
      d = clz64(mc) - 2;
      mc = mc << d;
      ec -= d;
      if (ep > ec || (ep == ec && p >= mc)) begin
         lg = p; el = ep; sl = sp; sm = mc; es = ec;
      end else begin
         lg = mc; el = ec; sl = sc; sm = p; es = ep;
      end
      d = el - es;
      if (d >= 63) sm = 64'd1;
      else if (d > 0) sm = (sm >> d) | 64'((sm & ((64'd1 << d) - 64'd1)) != 0);
      if (sp == sc) lg += sm;
      else begin
         lg -= sm;
         if (lg == 0) return 32'd0;
      end
      return f32_round(sl, lg, el);
   endfunction

   function automatic logic [31:0] int_to_f32(input logic [31:0] v);
      logic [31:0] mag;
      mag = v[31] ? -v : v;
      if (mag == 0) return 32'd0;
      return f32_round(v & 32'h8000_0000, {32'd0, mag}, 0);
   endfunction

   function automatic int unsigned clamp_u(input int unsigned v, input int unsigned hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   // Advance the model by one element transfer; queue a row result when a row closes
   task automatic matvec_accept(input logic signed [7:0] act, input logic signed [7:0] wgt,
                                input logic [31:0] act_scale, input logic [31:0] wgt_scale);
      int unsigned n, gs, rc, whole;
      logic [31:0] scale;
      row_result_type r;
      n = clamp_u(mv_row_length, qmv_pkg::MAX_ROW_LENGTH_DEF);
      gs = clamp_u(mv_group_size, qmv_pkg::MAX_GROUP_SIZE_DEF);
      rc = clamp_u(mv_row_count, qmv_pkg::MAX_ROW_COUNT);
      whole = (n / gs) * gs;
      if (mv_elem_pos < whole) begin
         mv_int_sum += 32'(int'(act) * int'(wgt));
         mv_group_pos++;
         if (mv_group_pos >= gs) begin
            scale = f32_fma(act_scale, wgt_scale, qmv_pkg::F32_NEG_ZERO);
            mv_row_acc = f32_fma(int_to_f32(mv_int_sum), scale, mv_row_acc);
            mv_int_sum = '0;
            mv_group_pos = 0;
         end
      end
      mv_elem_pos++;
      if (mv_elem_pos >= n) begin
         r.sum = mv_row_acc;
         r.idx = mv_cur_row[qmv_pkg::ROW_INDEX_W-1:0];
         r.last = (mv_cur_row + 1 >= rc);
         r.hand_set = 1'b0;
         r.hand_sum = '0;
         row_sums_due.push_back(r);
         mv_elem_pos = 0;
         mv_group_pos = 0;
         mv_int_sum = '0;
         mv_row_acc = '0;
         mv_cur_row = r.last ? 0 : mv_cur_row + 1;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: ready toggles at the falling edge, transfers are checked at the rising edge
   // ---------------------------------------------------------------------------------------
   initial rsp.ready = 1'b0;

   always @(negedge clock)
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      row_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (row_sums_due.size() == 0) begin
            report($sformatf("unexpected row result sum=%h idx=%0d", rsp.row_sum,
                             rsp.row_index));
         end else begin
            want = row_sums_due.pop_front();
            if (rsp.row_sum !== want.sum)
               report($sformatf("row %0d row_sum got %h want %h", want.idx, rsp.row_sum,
                                want.sum));
            if (want.hand_set && rsp.row_sum !== want.hand_sum)
               report($sformatf("row %0d row_sum got %h, table says %h", want.idx,
                                rsp.row_sum, want.hand_sum));
            if (rsp.row_index !== want.idx)
               report($sformatf("row_index got %0d want %0d", rsp.row_index, want.idx));
            if (rsp.last_row !== want.last)
               report($sformatf("row %0d last_row got %b want %b", want.idx, rsp.last_row,
                                want.last));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Element side
   // ---------------------------------------------------------------------------------------
   initial begin
      req.valid = 1'b0;
      req.act_q = '0;
      req.wgt_q = '0;
      req.act_scale = '0;
      req.wgt_scale = '0;
   end

   // One element transfer; valid is left high so back-to-back items need no re-raise
   task automatic send_element(input logic signed [7:0] act, input logic signed [7:0] wgt,
                               input logic [31:0] act_scale, input logic [31:0] wgt_scale);
      while ($urandom_range(99) < tx_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.act_q = act;
      req.wgt_q = wgt;
      req.act_scale = act_scale;
      req.wgt_scale = wgt_scale;
      do @(posedge clock); while (!req.ready);
      matvec_accept(act, wgt, act_scale, wgt_scale);
      items_sent++;
      @(negedge clock);
   endtask

   // Let every outstanding row drain, then give the float back end time to go quiet
   task automatic drain_rows();
      req.valid = 1'b0;
      while (row_sums_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [qmv_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [qmv_pkg::CSR_DATA_W-1:0] v);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         qmv_pkg::CSR_ROW_LENGTH: mv_row_length = v[qmv_pkg::ROW_LENGTH_W-1:0];
         qmv_pkg::CSR_GROUP_SIZE: mv_group_size = v[qmv_pkg::GROUP_SIZE_W-1:0];
         qmv_pkg::CSR_ROW_COUNT:  mv_row_count  = v[qmv_pkg::ROW_COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_shape(input int rl, input int gs, input int rc);
      drain_rows();
      csr_write(qmv_pkg::CSR_ROW_LENGTH, qmv_pkg::CSR_DATA_W'(rl));
      csr_write(qmv_pkg::CSR_GROUP_SIZE, qmv_pkg::CSR_DATA_W'(gs));
      csr_write(qmv_pkg::CSR_ROW_COUNT, qmv_pkg::CSR_DATA_W'(rc));
   endtask

   function automatic logic signed [7:0] pick_q();
      case ($urandom_range(9))
         0: return 8'sh80;
         1: return 8'sh7f;
         2: return 8'sh00;
         3: return 8'shff;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly moderate normals so sums stay finite; some raw bits and special encodings
   function automatic logic [31:0] pick_scale();
      logic [31:0] specials [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
                                     32'hff80_0000, 32'h7fc0_0000, 32'h7f80_0001,
                                     32'h0000_0001, 32'h007f_ffff, 32'h7f7f_ffff,
                                     32'h0080_0000};
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return specials[$urandom_range(9)];
      if (roll < 10) return $urandom;
      return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
   endfunction

   task automatic send_rows(input int rows);
      int n;
      n = clamp_u(mv_row_length, qmv_pkg::MAX_ROW_LENGTH_DEF);
      repeat (rows * n)
         send_element(pick_q(), pick_q(), pick_scale(), pick_scale());
   endtask

   // Directed: one element per row, group of one, so each row shows one group's math
   dir_row_type dir_tbl [14] = '{
      '{8'sd0,    8'sd0,    32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h0000_0000},
      '{8'sd1,    8'sd1,    32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h3f80_0000},
      '{-8'sd128, -8'sd128, 32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'h4680_0000},
      '{8'sd127,  -8'sd128, 32'h3f80_0000, 32'h3f80_0000, 1'b1, 32'hc67e_0000},
      '{8'sd127,  8'sd127,  32'h7fc0_0000, 32'h3f80_0000, 1'b1, 32'h7fc0_0000}, // NaN scale
      '{8'sd1,    8'sd1,    32'h7f80_0000, 32'h0000_0000, 1'b1, 32'h7fc0_0000}, // inf * 0
      '{8'sd1,    8'sd1,    32'h7f80_0000, 32'h3f80_0000, 1'b1, 32'h7f80_0000},
      '{-8'sd1,   8'sd1,    32'h7f80_0000, 32'h3f80_0000, 1'b1, 32'hff80_0000},
      '{8'sd1,    8'sd1,    32'h8000_0000, 32'h3f80_0000, 1'b1, 32'h0000_0000}, // -0 scale
      '{8'sd1,    8'sd1,    32'h0000_0001, 32'h3f80_0000, 1'b1, 32'h0000_0001}, // subnormal
      '{8'sd1,    8'sd1,    32'h7f7f_ffff, 32'h4000_0000, 1'b1, 32'h7f80_0000}, // overflow
      '{-8'sd128, 8'sd127,  32'h4000_0000, 32'h3f00_0000, 1'b0, 32'h0},
      '{8'sd93,   -8'sd77,  32'h3c23_d70a, 32'hbe4c_cccd, 1'b0, 32'h0},
      '{-8'sd5,   8'sd3,    32'h0080_0000, 32'h3f00_0000, 1'b0, 32'h0}
   };

   initial begin
      int rl, gs, rc, rows;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      tx_idle_pct = 8;
      rx_idle_pct = 72;

      // Reset shape: two 64-element rows, each in two groups of 32
      send_rows(2);

      // Directed table
      set_shape(1, 1, 3);
      foreach (dir_tbl[i]) begin
         send_element(dir_tbl[i].act, dir_tbl[i].wgt, dir_tbl[i].act_scale,
                      dir_tbl[i].wgt_scale);
         if (dir_tbl[i].hand_set) begin
            row_sums_due[row_sums_due.size()-1].hand_set = 1'b1;
            row_sums_due[row_sums_due.size()-1].hand_sum = dir_tbl[i].hand_sum;
         end
      end

      // Trailing elements past the last whole group
      set_shape(7, 3, 2);
      send_rows(3);
      // Row shorter than one group gives +0.0
      set_shape(3, 8, 2);
      send_rows(2);
      // Zero registers saturate to one
      set_shape(0, 0, 0);
      send_rows(4);
      // Oversized group saturates to 256, leaving two trailing elements
      set_shape(258, 511, 1);
      send_rows(1);
      // Row count beyond the index range: last_row never set here
      set_shape(2, 1, 16'h7fff);
      send_rows(3);

      // Random shapes; idling pattern swaps, then stops
      while (items_sent < 700) begin
         if (items_sent > 600) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (items_sent > 500) begin
            tx_idle_pct = 72;
            rx_idle_pct = 8;
         end
         rl = $urandom_range(1, 32);
         gs = ($urandom_range(4) == 0) ? $urandom_range(1, 48) : $urandom_range(1, 12);
         rc = $urandom_range(1, 4);
         rows = $urandom_range(1, 3);
         set_shape(rl, gs, rc);
         send_rows(1);
         // hold the sender until the pipe is empty, then carry on mid-phase
         if (rows > 1 && $urandom_range(3) == 0) begin
            req.valid = 1'b0;
            while (row_sums_due.size() != 0) @(negedge clock);
         end
         send_rows(rows - 1);
      end

      req.valid = 1'b0;
      while (row_sums_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (row_sums_due.size() != 0)
         report($sformatf("%0d row results never arrived", row_sums_due.size()));
      if (errors == 0)
         $display("PASS int8_group_quantized_matvec_core");
      else
         $display("FAIL int8_group_quantized_matvec_core");
      $finish;
   end

   // Watchdog: far above the slowest legal run
   initial begin
      #30ms;
      $display("FAIL int8_group_quantized_matvec_core");
      $finish;
   end

endmodule
